// ===== rtl/ashm_pkg.sv =====
// Shared types, constants and codes of the allocation size histogram monitor.
`default_nettype none

package ashm_pkg;

   // Histogram geometry.
   localparam int NUM_BUCKETS = 64;
   localparam int HIST_DEPTH  = 64;
   localparam int BKT_W       = 6;

   // Size bucketing constants.
   localparam logic [63:0] SMALL_LIMIT = 64'd256;
   localparam logic [9:0]  SMALL_ROUND = 10'd15;
   localparam int          LARGE_BASE  = 9;

   // Event modes.
   localparam logic [2:0] MODE_MALLOC   = 3'd0;
   localparam logic [2:0] MODE_FREE     = 3'd1;
   localparam logic [2:0] MODE_CALLOC   = 3'd2;
   localparam logic [2:0] MODE_REALLOC  = 3'd3;
   localparam logic [2:0] MODE_MEMALIGN = 3'd4;
   localparam logic [2:0] MODE_READ_BKT = 3'd5;
   localparam logic [2:0] MODE_READ_CNT = 3'd6;

   // Counter numbers for counter reads.
   localparam int NUM_CNT = 8;
   localparam logic [2:0] CNT_MALLOC   = 3'd0;
   localparam logic [2:0] CNT_FREE     = 3'd1;
   localparam logic [2:0] CNT_REALLOC  = 3'd2;
   localparam logic [2:0] CNT_CALLOC   = 3'd3;
   localparam logic [2:0] CNT_MEMALIGN = 3'd4;
   localparam logic [2:0] CNT_TOTAL    = 3'd5;
   localparam logic [2:0] CNT_GROW     = 3'd6;
   localparam logic [2:0] CNT_SAME     = 3'd7;

   // Input word.
   typedef struct packed {
      logic [2:0]       mode;
      logic [63:0]      request_size;
      logic [63:0]      element_count;
      logic             old_present;
      logic [63:0]      old_usable;
      logic [63:0]      new_usable;
      logic [BKT_W-1:0] read_index;
   } req_word_type;

   // Result word.
   typedef struct packed {
      logic [BKT_W-1:0] bucket_index;
      logic [63:0]      bucket_calls;
      logic [63:0]      bucket_byte_sum;
      logic [63:0]      counter_value;
      logic [63:0]      live_bytes_out;
      logic [63:0]      peak_bytes_out;
   } rsp_word_type;

   // One histogram entry.
   typedef struct packed {
      logic [63:0] calls;
      logic [63:0] bytes;
   } hist_entry_type;

   // Access command to the histogram memory.
   typedef struct packed {
      logic             rd_en;
      logic [BKT_W-1:0] rd_addr;
      logic             wr_en;
      logic [BKT_W-1:0] wr_addr;
   } hist_cmd_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SIZE,
      ST_BUCKET,
      ST_READ,
      ST_WRITE
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/alloc_size_histogram_monitor_top.sv =====
// Top level of the allocation size histogram monitor.
`default_nettype none

// The monitor takes one allocation trace word at a time and returns one
// result word for each. A word is worked in order: the calloc partial
// products are formed as it is taken, then the request size and the
// release of the old block, then the bucket and the new block, then the
// histogram read with the counter and peak update, and last the histogram
// write-back together with the result. Because of the read-modify-write of
// the single histogram memory, a new word is taken only once the last one
// has been written back; a result waiting on rsp_stall does not keep the
// next word out, only the one after it. Reset clears all statistics at
// once and needs no clearing pass.
module alloc_size_histogram_monitor_top import ashm_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_data
);

   // Map a request size to its histogram bucket: 16-byte steps up to 256, a leading-one detect above.
   function automatic logic [BKT_W-1:0] size_to_bucket(input logic [63:0] n);
      logic [9:0]  small_sum;
      logic [63:0] m;
      logic [6:0]  msb;
      logic [7:0]  raw;
      small_sum = {1'b0, n[8:0]} + SMALL_ROUND;
      m         = n - 64'd1;
      msb       = '0;
      for (int i = 0; i < 64; i++) begin
         if (m[i]) begin
            msb = 7'(i);
         end
      end
      raw = {1'b0, msb} + 8'(LARGE_BASE);
      if (raw > 8'(NUM_BUCKETS - 1)) begin
         raw = 8'(NUM_BUCKETS - 1);
      end
      if (n <= SMALL_LIMIT) begin
         return BKT_W'(small_sum[9:4]);
      end
      return BKT_W'(raw);
   endfunction

   state_type      state_ff, state_in;
   req_word_type   req_ff;
   logic [63:0]    pp_ll_ff;
   logic [31:0]    pp_lh_ff;
   logic [31:0]    pp_hl_ff;
   logic [63:0]    size_ff, size_in;
   logic [BKT_W-1:0] bucket_ff, bucket_in;
   logic           added_ff, added_in;
   logic [63:0]    live_ff, live_in;
   logic [63:0]    peak_ff, peak_in;
   logic [63:0]    cnt_ff [NUM_CNT];
   logic [63:0]    cnt_in [NUM_CNT];
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_word_type   rsp_data_ff, rsp_data_in;

   logic           accept;
   logic           out_free;
   logic           load_out;
   logic           is_alloc;
   logic           releases;
   hist_cmd_type   hist_cmd;
   hist_entry_type hist_wr;
   hist_entry_type hist_rd;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Modes that record a request and may add a block.
   assign is_alloc = (req_ff.mode == MODE_MALLOC) || (req_ff.mode == MODE_CALLOC) ||
                     (req_ff.mode == MODE_REALLOC) || (req_ff.mode == MODE_MEMALIGN);
   assign releases = req_ff.old_present &&
                     ((req_ff.mode == MODE_FREE) || (req_ff.mode == MODE_REALLOC));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_SIZE;
         ST_SIZE:   state_in = ST_BUCKET;
         ST_BUCKET: state_in = ST_READ;
         ST_READ:   state_in = ST_WRITE;
         ST_WRITE:  if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_stall        = 1'b1;
      load_out         = 1'b0;
      hist_cmd.rd_en   = 1'b0;
      hist_cmd.rd_addr = bucket_ff;
      hist_cmd.wr_en   = 1'b0;
      hist_cmd.wr_addr = bucket_ff;
      case (state_ff)
         ST_IDLE:  req_stall = 1'b0;
         ST_READ:  hist_cmd.rd_en = 1'b1;
         ST_WRITE: begin
            load_out       = out_free;
            hist_cmd.wr_en = out_free && is_alloc;
         end
         default: req_stall = 1'b1;
      endcase
   end

   // Input capture and calloc partial products; each is one 32x32 product.
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff   <= req_data;
         pp_ll_ff <= {32'd0, req_data.request_size[31:0]} *
                     {32'd0, req_data.element_count[31:0]};
         pp_lh_ff <= 32'(req_data.request_size[31:0] * req_data.element_count[63:32]);
         pp_hl_ff <= 32'(req_data.request_size[63:32] * req_data.element_count[31:0]);
      end
   end

   // Request size, bucket, live bytes and peak, one step per state.
   always_comb begin
      size_in   = size_ff;
      bucket_in = bucket_ff;
      added_in  = added_ff;
      live_in   = live_ff;
      peak_in   = peak_ff;
      case (state_ff)
         ST_SIZE: begin
            if (req_ff.mode == MODE_CALLOC) begin
               size_in = pp_ll_ff + {pp_lh_ff + pp_hl_ff, 32'd0};
            end else begin
               size_in = req_ff.request_size;
            end
            if (releases) begin
               live_in = live_ff - req_ff.old_usable;
            end
         end
         ST_BUCKET: begin
            if (req_ff.mode == MODE_READ_BKT) begin
               bucket_in = req_ff.read_index;
            end else begin
               bucket_in = size_to_bucket(size_ff);
            end
            added_in = is_alloc && (req_ff.new_usable != 64'd0);
            if (added_in) begin
               live_in = live_ff + req_ff.new_usable;
            end
         end
         ST_READ: begin
            if (added_ff && (live_ff > peak_ff)) begin
               peak_in = live_ff;
            end
         end
         default: begin
            size_in = size_ff;
         end
      endcase
   end

   // Kind counters, total bytes and realloc outcomes.
   always_comb begin
      for (int i = 0; i < NUM_CNT; i++) begin
         cnt_in[i] = cnt_ff[i];
      end
      if (state_ff == ST_READ) begin
         case (req_ff.mode)
            MODE_MALLOC:   cnt_in[CNT_MALLOC]   = cnt_ff[CNT_MALLOC] + 64'd1;
            MODE_CALLOC:   cnt_in[CNT_CALLOC]   = cnt_ff[CNT_CALLOC] + 64'd1;
            MODE_MEMALIGN: cnt_in[CNT_MEMALIGN] = cnt_ff[CNT_MEMALIGN] + 64'd1;
            MODE_FREE: begin
               if (req_ff.old_present) begin
                  cnt_in[CNT_FREE] = cnt_ff[CNT_FREE] + 64'd1;
               end
            end
            MODE_REALLOC: begin
               cnt_in[CNT_REALLOC] = cnt_ff[CNT_REALLOC] + 64'd1;
               if (req_ff.old_present && (req_ff.request_size <= req_ff.old_usable)) begin
                  cnt_in[CNT_SAME] = cnt_ff[CNT_SAME] + 64'd1;
               end else begin
                  cnt_in[CNT_GROW] = cnt_ff[CNT_GROW] + 64'd1;
               end
            end
            default: cnt_in[CNT_TOTAL] = cnt_ff[CNT_TOTAL];
         endcase
         if (is_alloc) begin
            cnt_in[CNT_TOTAL] = cnt_ff[CNT_TOTAL] + size_ff;
         end
      end
   end

   // Histogram update from the entry just read.
   always_comb begin
      hist_wr.calls = hist_rd.calls + 64'd1;
      hist_wr.bytes = hist_rd.bytes + size_ff;
   end

   // Result word.
   always_comb begin
      rsp_data_in                 = '0;
      rsp_data_in.live_bytes_out  = live_ff;
      rsp_data_in.peak_bytes_out  = peak_ff;
      case (req_ff.mode)
         MODE_MALLOC, MODE_CALLOC, MODE_REALLOC, MODE_MEMALIGN: begin
            rsp_data_in.bucket_index    = bucket_ff;
            rsp_data_in.bucket_calls    = hist_wr.calls;
            rsp_data_in.bucket_byte_sum = hist_wr.bytes;
         end
         MODE_READ_BKT: begin
            rsp_data_in.bucket_index = req_ff.read_index;
            if ({1'b0, req_ff.read_index} < (BKT_W + 1)'(NUM_BUCKETS)) begin
               rsp_data_in.bucket_calls    = hist_rd.calls;
               rsp_data_in.bucket_byte_sum = hist_rd.bytes;
            end
         end
         MODE_READ_CNT: begin
            if (req_ff.read_index < BKT_W'(NUM_CNT)) begin
               rsp_data_in.counter_value = cnt_ff[req_ff.read_index[2:0]];
            end
         end
         default: rsp_data_in.counter_value = '0;
      endcase
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Control and statistics registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         live_ff      <= '0;
         peak_ff      <= '0;
         added_ff     <= 1'b0;
         for (int i = 0; i < NUM_CNT; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         live_ff      <= live_in;
         peak_ff      <= peak_in;
         added_ff     <= added_in;
         for (int i = 0; i < NUM_CNT; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   // Working registers of the current word.
   always_ff @(posedge clock) begin
      size_ff   <= size_in;
      bucket_ff <= bucket_in;
   end

   ashm_hist u_hist (
      .clock   (clock),
      .reset   (reset),
      .cmd     (hist_cmd),
      .wr_data (hist_wr),
      .rd_data (hist_rd)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/ashm_hist.sv =====
// Histogram memory with per-entry valid bits and a registered read port.
`default_nettype none

module ashm_hist import ashm_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire hist_cmd_type   cmd,
   input  wire hist_entry_type wr_data,
   output hist_entry_type      rd_data
);

   hist_entry_type         mem [HIST_DEPTH];
   hist_entry_type         rd_ff;
   logic                   rd_valid_ff;
   logic                   rd_valid_in;
   logic [HIST_DEPTH-1:0]  valid_ff;
   logic [HIST_DEPTH-1:0]  valid_in;

   // An entry becomes valid when first written; reset clears all at once.
   always_comb begin
      valid_in = valid_ff;
      if (cmd.wr_en) begin
         valid_in[cmd.wr_addr] = 1'b1;
      end
      rd_valid_in = rd_valid_ff;
      if (cmd.rd_en) begin
         rd_valid_in = valid_ff[cmd.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   // Memory array: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[cmd.rd_addr];
      end
   end

   // An entry never written reads as zero.
   assign rd_data = rd_valid_ff ? rd_ff : '0;

endmodule

`default_nettype wire

// ===== tb/sv/alloc_size_histogram_monitor_top_tb.sv =====
// Self-checking testbench for the allocation size histogram monitor.
module alloc_size_histogram_monitor_top_tb;
   import ashm_pkg::*;

   // The one mode code that the package leaves unnamed.
   localparam logic [2:0] MODE_UNUSED = 3'd7;
   localparam int HOLD_CYCLES = 300;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;

   // Predicted statistics of the monitor.
   logic [63:0] model_calls [0:HIST_DEPTH-1];
   logic [63:0] model_bytes [0:HIST_DEPTH-1];
   logic [63:0] model_kinds [0:4];
   logic [63:0] model_total;
   logic [63:0] model_grow;
   logic [63:0] model_same;
   logic [63:0] model_live;
   logic [63:0] model_peak;

   // Result words still owed by the monitor, oldest first.
   rsp_word_type pending_stats [$];

   int send_idle_pct = 0;
   int rcv_idle_pct  = 0;
   int words_sent    = 0;
   int words_checked = 0;
   int mismatches    = 0;

   // Long output hold-off: the test flips the toggle, the stall process counts.
   logic hold_toggle = 1'b0;
   logic hold_seen   = 1'b0;
   int   hold_left   = 0;

   alloc_size_histogram_monitor_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

   // Bucket of a request size: 16-byte steps up to 256, then powers of two.
   function automatic logic [BKT_W-1:0] bucket_of(input logic [63:0] n);
      logic [63:0] limit;
      int          b;
      if (n <= 64'd256) return BKT_W'((n + 64'd15) >> 4);
      limit = 64'd512;
      b = 17;
      while (n > limit && b < NUM_BUCKETS - 1) begin
         b++;
         limit = limit << 1;
      end
      return BKT_W'(b);
   endfunction

   function automatic logic [BKT_W-1:0] note_request(input logic [63:0] n);
      logic [BKT_W-1:0] b;
      b = bucket_of(n);
      model_calls[b] += 64'd1;
      model_bytes[b] += n;
      model_total += n;
      return b;
   endfunction

   // A failed allocation returns zero usable bytes and leaves live and peak alone.
   function automatic void add_live(input logic [63:0] usable);
      if (usable != 64'd0) begin
         model_live += usable;
         if (model_live > model_peak) model_peak = model_live;
      end
   endfunction

   // Updates the predicted statistics for one trace word and returns its result.
   function automatic rsp_word_type account_event(input req_word_type w);
      rsp_word_type r;
      logic         show;
      r = '0;
      show = 1'b0;
      case (w.mode)
         MODE_MALLOC, MODE_MEMALIGN: begin
            if (w.mode == MODE_MALLOC) model_kinds[CNT_MALLOC] += 64'd1;
            else model_kinds[CNT_MEMALIGN] += 64'd1;
            r.bucket_index = note_request(w.request_size);
            show = 1'b1;
            add_live(w.new_usable);
         end
         MODE_FREE: begin
            // A free of a null pointer is not even counted.
            if (w.old_present) begin
               model_kinds[CNT_FREE] += 64'd1;
               model_live -= w.old_usable;
            end
         end
         MODE_CALLOC: begin
            model_kinds[CNT_CALLOC] += 64'd1;
            r.bucket_index = note_request(w.request_size * w.element_count);
            show = 1'b1;
            add_live(w.new_usable);
         end
         MODE_REALLOC: begin
            model_kinds[CNT_REALLOC] += 64'd1;
            if (w.old_present && w.request_size <= w.old_usable) model_same += 64'd1;
            else model_grow += 64'd1;
            r.bucket_index = note_request(w.request_size);
            show = 1'b1;
            if (w.old_present) model_live -= w.old_usable;
            add_live(w.new_usable);
         end
         MODE_READ_BKT: begin
            r.bucket_index = w.read_index;
            show = (w.read_index < NUM_BUCKETS);
         end
         MODE_READ_CNT: begin
            if (w.read_index < NUM_CNT) begin
               case (w.read_index[2:0])
                  CNT_TOTAL: r.counter_value = model_total;
                  CNT_GROW:  r.counter_value = model_grow;
                  CNT_SAME:  r.counter_value = model_same;
                  default:   r.counter_value = model_kinds[w.read_index[2:0]];
               endcase
            end
         end
         default: begin
         end
      endcase
      if (show) begin
         r.bucket_calls = model_calls[r.bucket_index];
         r.bucket_byte_sum = model_bytes[r.bucket_index];
      end
      r.live_bytes_out = model_live;
      r.peak_bytes_out = model_peak;
      return r;
   endfunction

   function automatic req_word_type make_word(input logic [2:0] mode,
                                              input logic [63:0] size,
                                              input logic [63:0] elems,
                                              input logic present,
                                              input logic [63:0] old_use,
                                              input logic [63:0] new_use,
                                              input logic [BKT_W-1:0] idx);
      req_word_type w;
      w.mode = mode;
      w.request_size = size;
      w.element_count = elems;
      w.old_present = present;
      w.old_usable = old_use;
      w.new_usable = new_use;
      w.read_index = idx;
      return w;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Mostly small sizes, some near powers of two, some anywhere in 64 bits.
   function automatic logic [63:0] rand_size();
      int unsigned sh;
      sh = $urandom_range(63);
      case ($urandom_range(9))
         0, 1, 2, 3: return 64'($urandom_range(300));
         4, 5:       return 64'($urandom_range(1 << 20));
         6, 7:       return (64'd1 << sh) - 64'd1 + 64'($urandom_range(2));
         default:    return rand64();
      endcase
   endfunction

   function automatic req_word_type random_word();
      req_word_type w;
      int unsigned  pick;
      pick = $urandom_range(99);
      if (pick < 28) w.mode = MODE_MALLOC;
      else if (pick < 43) w.mode = MODE_FREE;
      else if (pick < 53) w.mode = MODE_CALLOC;
      else if (pick < 68) w.mode = MODE_REALLOC;
      else if (pick < 76) w.mode = MODE_MEMALIGN;
      else if (pick < 86) w.mode = MODE_READ_BKT;
      else if (pick < 96) w.mode = MODE_READ_CNT;
      else w.mode = MODE_UNUSED;
      w.request_size = rand_size();
      w.element_count = ($urandom_range(3) == 0) ? rand64() : 64'($urandom_range(40));
      w.old_present = 1'($urandom_range(1));
      w.old_usable = ($urandom_range(3) == 0) ? rand64() : rand_size();
      if ($urandom_range(4) == 0) w.new_usable = 64'd0;
      else if ($urandom_range(3) == 0) w.new_usable = rand64();
      else w.new_usable = w.request_size + 64'($urandom_range(15));
      w.read_index = BKT_W'($urandom_range(63));
      if (w.mode == MODE_READ_CNT && $urandom_range(3) != 0)
         w.read_index = BKT_W'($urandom_range(NUM_CNT - 1));
      return w;
   endfunction

   // Offers one word, waits for it to be taken and records its prediction.
   task automatic send_word(input req_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      pending_stats.push_back(account_event(w));
      words_sent++;
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (pending_stats.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Bucket boundaries, the saturating top bucket and failed allocations.
   task automatic test_size_edges();
      send_word(make_word(MODE_MALLOC, 64'd0, 64'd0, 1'b0, 64'd0, 64'd0, '0));
      send_word(make_word(MODE_MALLOC, 64'd1, 64'd0, 1'b0, 64'd0, 64'd16, '0));
      send_word(make_word(MODE_MALLOC, 64'd256, 64'd0, 1'b0, 64'd0, 64'd256, '0));
      send_word(make_word(MODE_MALLOC, 64'd257, 64'd0, 1'b0, 64'd0, 64'd264, '0));
      send_word(make_word(MODE_MALLOC, 64'd512, 64'd0, 1'b0, 64'd0, 64'd512, '0));
      send_word(make_word(MODE_MALLOC, 64'd513, 64'd0, 1'b0, 64'd0, 64'd528, '0));
      send_word(make_word(MODE_MALLOC, '1, '1, 1'b1, '1, 64'd0, '1));
      send_word(make_word(MODE_MEMALIGN, 64'd4096, 64'd0, 1'b0, 64'd0, 64'd4096, '0));
   endtask

   // Calloc overflow and every realloc outcome.
   task automatic test_calloc_realloc();
      send_word(make_word(MODE_CALLOC, 64'd1 << 33, 64'd1 << 32, 1'b0, 64'd0, 64'd0, '0));
      send_word(make_word(MODE_CALLOC, 64'd16, 64'd10, 1'b0, 64'd0, 64'd160, '0));
      send_word(make_word(MODE_REALLOC, 64'd100, 64'd0, 1'b1, 64'd256, 64'd256, '0));
      send_word(make_word(MODE_REALLOC, 64'd300, 64'd0, 1'b1, 64'd256, 64'd320, '0));
      send_word(make_word(MODE_REALLOC, 64'd64, 64'd0, 1'b0, 64'd999, 64'd64, '0));
      send_word(make_word(MODE_REALLOC, 64'd10, 64'd0, 1'b1, 64'd16, 64'd0, '0));
   endtask

   // Frees of real and null blocks, live underflow and the unused mode.
   task automatic test_free_cases();
      send_word(make_word(MODE_FREE, 64'd0, 64'd0, 1'b1, 64'd160, 64'd0, '0));
      send_word(make_word(MODE_FREE, 64'd0, 64'd0, 1'b0, 64'd1000, 64'd0, '0));
      send_word(make_word(MODE_FREE, '1, '1, 1'b1, '1, '1, '1));
      send_word(make_word(MODE_UNUSED, 64'd77, 64'd3, 1'b1, 64'd5, 64'd80, 6'd9));
   endtask

   // Bucket and counter reads, including counter numbers past the last one.
   task automatic test_reads();
      send_word(make_word(MODE_READ_BKT, '1, '1, 1'b1, '1, '1, 6'd17));
      send_word(make_word(MODE_READ_BKT, 64'd0, 64'd0, 1'b0, 64'd0, 64'd0, 6'd63));
      send_word(make_word(MODE_READ_CNT, 64'd0, 64'd0, 1'b0, 64'd0, 64'd0, 6'(CNT_REALLOC)));
      send_word(make_word(MODE_READ_CNT, 64'd0, 64'd0, 1'b0, 64'd0, 64'd0, 6'(CNT_GROW)));
      send_word(make_word(MODE_READ_CNT, 64'd0, 64'd0, 1'b0, 64'd0, 64'd0, 6'(CNT_SAME)));
      send_word(make_word(MODE_READ_CNT, '1, '1, 1'b1, '1, '1, 6'd63));
   endtask

   task automatic test_random_traffic(input int count);
      repeat (count) send_word(random_word());
   endtask

   // The output holds off for a long stretch while words keep coming.
   task automatic test_stalled_output();
      int saved_idle;
      saved_idle = send_idle_pct;
      send_idle_pct = 0;
      hold_toggle <= ~hold_toggle;
      repeat (40) send_word(random_word());
      send_idle_pct = saved_idle;
   endtask

   // The input pauses until every owed result has come back.
   task automatic test_drain_pause();
      repeat (20) send_word(random_word());
      wait_results_drained();
      repeat (20) send_word(random_word());
   endtask

   // Output stall: a counted hold-off when asked, otherwise random.
   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
   end

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Each word taken from the output is compared with the oldest prediction.
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_stats.size() == 0) begin
            $display("%0t: unexpected result word, expected none, got %h", $time, rsp_data);
            mismatches++;
         end else begin
            want = pending_stats.pop_front();
            check_field("bucket_index", 64'(want.bucket_index), 64'(rsp_data.bucket_index));
            check_field("bucket_calls", want.bucket_calls, rsp_data.bucket_calls);
            check_field("bucket_byte_sum", want.bucket_byte_sum, rsp_data.bucket_byte_sum);
            check_field("counter_value", want.counter_value, rsp_data.counter_value);
            check_field("live_bytes_out", want.live_bytes_out, rsp_data.live_bytes_out);
            check_field("peak_bytes_out", want.peak_bytes_out, rsp_data.peak_bytes_out);
            words_checked++;
         end
      end
   end

   initial begin
      foreach (model_calls[i]) begin
         model_calls[i] = '0;
         model_bytes[i] = '0;
      end
      foreach (model_kinds[i]) model_kinds[i] = '0;
      model_total = '0;
      model_grow = '0;
      model_same = '0;
      model_live = '0;
      model_peak = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 23;
      rcv_idle_pct = 50;
      test_size_edges();
      test_calloc_realloc();
      test_free_cases();
      test_reads();
      test_random_traffic(340);
      test_stalled_output();
      wait_results_drained();

      send_idle_pct = 50;
      rcv_idle_pct = 23;
      test_random_traffic(320);
      test_drain_pause();
      wait_results_drained();

      send_idle_pct = 0;
      rcv_idle_pct = 0;
      test_random_traffic(330);
      wait_results_drained();

      $display("Checked %0d result words for %0d trace words over all event kinds,", 
               words_checked, words_sent);
      $display("reads and the unused code, with idle gaps and long output hold-offs.");
      if (mismatches == 0 && pending_stats.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/ashm_pkg.sv
rtl/ashm_hist.sv
rtl/alloc_size_histogram_monitor_top.sv
tb/sv/alloc_size_histogram_monitor_top_tb.sv
